/* hdl/pbmr_pkg.sv */
// Shared types and constants for the polar minimum-range binning block.
package pbmr_pkg;

   localparam int unsigned NEAR_MM = 20;
   localparam int unsigned ATAN_ENTRIES = 24;

   typedef enum logic [1:0] {
      CSR_NUM_BINS   = 2'd0,
      CSR_CAP_MM     = 2'd1,
      CSR_MIN_POINTS = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      logic               operation;
      logic signed [15:0] x_mm;
      logic signed [15:0] y_mm;
      logic [9:0]         bin_select;
   } req_type;

   typedef struct packed {
      logic [9:0]  read_bin;
      logic [15:0] norm_range;
      logic [7:0]  hit_total;
   } rsp_type;

   // atan(2^-i) in units of 2^32 per turn
   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

/* hdl/pbmr_ram.sv */
// Generic simple dual-port RAM (separate write and read addresses) with registered read.
module pbmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* hdl/polar_bin_min_range.sv */
// Add point: range gate, STEPS (CORDIC_STEPS, at most ATAN_ENTRIES) vectoring steps, 16 square-root
// steps, then bin select, store read and store write; a point outside the range gate is dropped.
// Read bin: store read, store data (clears the bin when it is in range), 17 divide steps, output;
// the output step waits while an older result is still stalled.
// One item at a time: the next item is accepted only while the sequencer is idle.
// Synchronous active-high reset, then a clearing pass over all MAX_BINS bins with input stalled.
module polar_bin_min_range #(
   parameter int MAX_BINS = 1024,
   parameter int CORDIC_STEPS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbmr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbmr_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [14:0]       csr_wdata
);
   import pbmr_pkg::*;

   localparam int AW = $clog2(MAX_BINS);
   localparam int NBW = $clog2(MAX_BINS + 1);
   localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SQ, ST_CORDIC, ST_SQRT, ST_BIN, ST_RDWAIT, ST_UPDATE,
      ST_RDBIN, ST_RDDATA, ST_DIV, ST_OUT
   } state_type;

   // configuration registers
   logic [10:0] num_bins_ff;
   logic [14:0] cap_ff;
   logic [7:0]  min_points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff   <= 11'd580;
         cap_ff        <= 15'd5000;
         min_points_ff <= 8'd2;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NUM_BINS:   num_bins_ff   <= csr_wdata[10:0];
            CSR_CAP_MM:     cap_ff        <= csr_wdata;
            CSR_MIN_POINTS: min_points_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // effective bin count and cap
   logic [NBW-1:0] nb;
   logic [14:0]    cap;
   always_comb begin
      if (num_bins_ff == 11'd0) begin
         nb = NBW'(1);
      end else if (32'(num_bins_ff) > 32'(MAX_BINS)) begin
         nb = NBW'(MAX_BINS);
      end else begin
         nb = NBW'(num_bins_ff);
      end
      cap = (cap_ff == 15'd0) ? 15'd1 : cap_ff;
   end

   // bin store
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [15:0]   mr_wdata, mr_rdata;
   logic [7:0]    hc_wdata, hc_rdata;

   pbmr_ram #(.WIDTH(16), .DEPTH(MAX_BINS)) u_min_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(mr_wdata),
      .rd_addr(ram_raddr), .rd_data(mr_rdata)
   );
   pbmr_ram #(.WIDTH(8), .DEPTH(MAX_BINS)) u_hit_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(hc_wdata),
      .rd_addr(ram_raddr), .rd_data(hc_rdata)
   );

   state_type state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic signed [37:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] z_ff, z_in;
   logic [4:0]  step_ff, step_in;
   logic [32:0] sq_ff, sq_in;          // squared distance, also sqrt remainder
   logic [15:0] root_ff, root_in;
   logic [9:0]  sel_ff, sel_in;
   logic [7:0]  hits_ff, hits_in;
   logic [31:0] rem_ff, rem_in;       // divide remainder / numerator
   logic [16:0] quo_ff, quo_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic signed [15:0] px_ff, px_in, py_ff, py_in;

   // shared add/subtract unit (CORDIC, sqrt trial and divide trial)
   logic signed [38:0] alu_a, alu_b, alu_sum;
   logic               alu_sub;
   assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

   logic signed [37:0] xs, ys;
   assign xs = cx_ff >>> step_ff;
   assign ys = cy_ff >>> step_ff;

   logic [32:0] sq_now;
   logic [15:0] mr_eff;
   logic [15:0] dval;
   logic [32:0] u_clamp;
   logic [43:0] bin_prod;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      z_in         = z_ff;
      step_in      = step_ff;
      sq_in        = sq_ff;
      root_in      = root_ff;
      sel_in       = sel_ff;
      hits_in      = hits_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_raddr    = addr_ff;
      mr_wdata     = 16'hFFFF;
      hc_wdata     = 8'd0;
      alu_a        = '0;
      alu_b        = '0;
      alu_sub      = 1'b0;
      sq_now       = 33'(32'(px_ff * px_ff)) + 33'(32'(py_ff * py_ff));
      mr_eff       = '0;
      dval         = '0;
      u_clamp      = '0;
      bin_prod     = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               px_in  = req_data.x_mm;
               py_in  = req_data.y_mm;
               sel_in = req_data.bin_select;
               state_in = (req_data.operation == OP_READ) ? ST_RDBIN : ST_SQ;
            end
         end
         ST_SQ: begin
            // squared distance and range gate, CORDIC pre-rotation
            sq_in   = sq_now;
            root_in = '0;
            step_in = '0;
            if (sq_now < 33'(NEAR_MM * NEAR_MM) || sq_now > 33'(cap * cap)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CORDIC;
               if (px_ff < 0) begin
                  if (py_ff >= 0) begin
                     cx_in = 38'(py_ff) <<< 20;
                     cy_in = -(38'(px_ff) <<< 20);
                     z_in  = 34'sd1 <<< 30;
                  end else begin
                     cx_in = -(38'(py_ff) <<< 20);
                     cy_in = 38'(px_ff) <<< 20;
                     z_in  = -(34'sd1 <<< 30);
                  end
               end else begin
                  cx_in = 38'(px_ff) <<< 20;
                  cy_in = 38'(py_ff) <<< 20;
                  z_in  = '0;
               end
            end
         end
         ST_CORDIC: begin
            // one vectoring step: x on the shared unit, y and z alongside
            alu_a   = 39'(cx_ff);
            alu_b   = 39'(ys);
            alu_sub = (cy_ff < 0);
            cx_in   = 38'(alu_sum);
            if (cy_ff >= 0) begin
               cy_in = cy_ff - xs;
               z_in  = z_ff + 34'(atan_entry(step_ff));
            end else begin
               cy_in = cy_ff + xs;
               z_in  = z_ff - 34'(atan_entry(step_ff));
            end
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_SQRT;
               step_in  = 5'd15;
            end
         end
         ST_SQRT: begin
            // one result bit per cycle, restoring square root
            alu_a   = 39'(sq_ff);
            alu_b   = 39'(({33'd0, root_ff} << (step_ff + 5'd1)) + (49'd1 << (2 * step_ff)));
            alu_sub = 1'b1;
            if (alu_sum >= 0) begin
               sq_in   = 33'(alu_sum);
               root_in = root_ff | (16'd1 << step_ff);
            end
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            // u = z + 2^31 clamped, bin = floor(u * nb / 2^32)
            if (z_ff + 34'sd2147483648 < 0) begin
               u_clamp = '0;
            end else if (z_ff + 34'sd2147483648 > 34'sd4294967295) begin
               u_clamp = 33'h0FFFFFFFF;
            end else begin
               u_clamp = 33'(z_ff + 34'sd2147483648);
            end
            bin_prod = 44'(u_clamp[31:0]) * 44'(nb);
            if (44'(bin_prod[43:32]) >= 44'(nb)) begin
               addr_in = AW'(nb - NBW'(1));
            end else begin
               addr_in = AW'(bin_prod[43:32]);
            end
            state_in = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_we   = 1'b1;
            mr_wdata = (root_ff < mr_rdata) ? root_ff : mr_rdata;
            hc_wdata = (hc_rdata == 8'hFF) ? hc_rdata : hc_rdata + 8'd1;
            state_in = ST_IDLE;
         end
         ST_RDBIN: begin
            addr_in  = AW'(sel_ff);
            ram_raddr = AW'(sel_ff);
            state_in = ST_RDDATA;
         end
         ST_RDDATA: begin
            if (32'(sel_ff) < 32'(nb)) begin
               hits_in = hc_rdata;
               mr_eff  = (mr_rdata < 16'(cap)) ? mr_rdata : 16'(cap);
               dval    = (hc_rdata < min_points_ff) ? 16'(cap) : mr_eff;
               ram_we  = 1'b1;
            end else begin
               hits_in = '0;
               dval    = 16'(cap);
            end
            if (dval < 16'(NEAR_MM)) begin
               dval = 16'(NEAR_MM);
            end
            rem_in  = {dval, 16'd0};
            quo_in  = '0;
            step_in = 5'd16;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // quotient bit step of (d << 16) / cap, from the top bit down
            alu_a   = 39'(rem_ff);
            alu_b   = 39'({17'd0, cap} << step_ff);
            alu_sub = 1'b1;
            if (alu_sum >= 0) begin
               rem_in = 32'(alu_sum);
               quo_in = quo_ff | (17'd1 << step_ff);
            end
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.read_bin     = sel_ff;
               rsp_in.norm_range   = quo_ff[16] ? 16'hFFFF : quo_ff[15:0];
               rsp_in.hit_total    = hits_ff;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
      sq_ff   <= sq_in;
      root_ff <= root_in;
      sel_ff  <= sel_in;
      hits_ff <= hits_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // a result waiting under stall keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed under stall");

   // a result only follows the output step of a read
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_OUT)
      else $error("result item without read");

   // the clearing pass blocks input items
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall)
      else $error("item accepted during clearing pass");
`endif

endmodule
